// ----- rtl/osc52_pkg.sv -----
// Shared types, constants and the base64 character function of the OSC 52 encoder.
package osc52_pkg;

    localparam int HDR_LEN = 7;

    // Character slots of one beat sequence: header, four data slots, terminator.
    localparam logic [3:0] POS_HDR_FIRST  = 4'd0;
    localparam logic [3:0] POS_HDR_LAST   = 4'd6;
    localparam logic [3:0] POS_DATA_FIRST = 4'd7;
    localparam logic [3:0] POS_DATA_LAST  = 4'd10;
    localparam logic [3:0] POS_BEL        = 4'd11;

    localparam logic [7:0] BEL_CHAR = 8'h07;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [7:0] HDR_CHARS [HDR_LEN] = '{
        8'h1B, 8'h5D, 8'h35, 8'h32, 8'h3B, 8'h63, 8'h3B
    };

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Work handed from the front to the back for one input item.
    typedef struct packed {
        logic        hdr;     // emit the seven header characters
        logic        dat;     // emit four data slots
        logic        bel;     // emit the terminator
        logic [2:0]  nsx;     // data slots that carry sextets, the rest are padding
        logic [23:0] triple;  // bits of the group, first byte highest
    } osc52_job_t;

    // Standard base64 alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ----- rtl/osc52_base64_encoder.sv -----
// Top level of the OSC 52 clipboard encoder: front end, job queue and sequencer.
//
// Each input beat carries one byte of clipboard text and the output stream
// carries the OSC 52 sequence ESC ] 5 2 ; c ; <base64> BEL, one character per
// beat. The output port sends at most one character per cycle while m_tready
// holds. An item causes no characters for the first two bytes of a group and
// four for the third; the first item of a text adds seven header characters
// and the closing item up to five more. A two-entry job queue lets the front
// end keep accepting items while the character sequencer drains earlier
// ones. Setting the disable register drops any partial text and consumes
// items without output; write it only while the block is idle.
module osc52_base64_encoder
    import osc52_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,   // osc_disable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // end_of_text
    input  logic        s_tuser,    // [0] byte_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_char
    output logic        m_tlast,    // run_last
    output logic        m_tuser     // [0] seq_end
);

    osc52_job_t  push_job;
    osc52_job_t  head_job;
    logic        push;
    logic        full;
    logic        pop;
    logic        head_valid;

    assign cfg_ready = 1'b1;

    osc52_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .q_full    (full),
        .q_push    (push),
        .q_job     (push_job)
    );

    osc52_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    osc52_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (head_valid),
        .q_job    (head_job),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/osc52_front.sv -----
// Front end: accepts input beats, tracks the base64 group and builds jobs.
module osc52_front
    import osc52_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output osc52_job_t  q_job
);

    logic        disable_reg;
    logic [1:0]  fill_reg, fill_next;
    logic [15:0] held_reg, held_next;
    logic        hdr_sent_reg, hdr_sent_next;

    logic        accept;
    logic        close;
    logic        full_grp;
    logic [1:0]  fill_after;
    logic [15:0] held_after;
    logic        flush;

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;

    // A beat without a byte always closes the text.
    assign close    = s_tlast | ~s_tuser;
    assign full_grp = s_tuser & (fill_reg == 2'd2);

    always_comb
    begin
        if (!s_tuser) begin
            fill_after = fill_reg;
            held_after = held_reg;
        end else if (full_grp) begin
            fill_after = 2'd0;
            held_after = 16'h0000;
        end else begin
            fill_after = fill_reg + 2'd1;
            held_after = {held_reg[7:0], s_tdata};
        end
    end

    assign flush = close & (fill_after != 2'd0);

    always_comb
    begin
        q_job.hdr = ~hdr_sent_reg;
        q_job.dat = full_grp | flush;
        q_job.bel = close;
        if (full_grp) begin
            q_job.nsx    = 3'd4;
            q_job.triple = {held_reg, s_tdata};
        end else if (fill_after == 2'd1) begin
            q_job.nsx    = 3'd2;
            q_job.triple = {held_after[7:0], 16'h0000};
        end else begin
            q_job.nsx    = 3'd3;
            q_job.triple = {held_after, 8'h00};
        end
    end

    // Beats that cause no character push nothing.
    assign q_push = accept & ~disable_reg & (~hdr_sent_reg | full_grp | close);

    always_comb
    begin
        fill_next     = fill_reg;
        held_next     = held_reg;
        hdr_sent_next = hdr_sent_reg;
        if (accept) begin
            if (disable_reg || close) begin
                fill_next     = 2'd0;
                held_next     = 16'h0000;
                hdr_sent_next = 1'b0;
            end else begin
                fill_next     = fill_after;
                held_next     = held_after;
                hdr_sent_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            disable_reg  <= 1'b0;
            fill_reg     <= 2'd0;
            held_reg     <= 16'h0000;
            hdr_sent_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                disable_reg <= cfg_data;
            end
            fill_reg     <= fill_next;
            held_reg     <= held_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

endmodule

// ----- rtl/osc52_queue.sv -----
// Short job queue between the front end and the character sequencer.
module osc52_queue
    import osc52_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  osc52_job_t  push_job,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output osc52_job_t  head_job
);

    osc52_job_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/osc52_back.sv -----
// Back end: walks each job one character per cycle, unless the output stalls, into the output register.
module osc52_back
    import osc52_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  osc52_job_t  q_job,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic        cur_valid_reg;
    osc52_job_t  cur_job_reg;
    logic [3:0]  pos_reg;
    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;
    logic        out_end_reg;

    logic        out_load;
    logic        emit;
    logic        cur_last;
    logic [3:0]  pos_next;
    logic [3:0]  start_pos;
    logic [7:0]  cur_char;
    logic [1:0]  slot;
    logic [5:0]  sext;

    assign out_load = ~out_valid_reg | m_tready;
    assign emit     = cur_valid_reg & out_load;
    assign q_pop    = q_valid & (~cur_valid_reg | (emit & cur_last));

    always_comb
    begin
        if (q_job.hdr) begin
            start_pos = POS_HDR_FIRST;
        end else if (q_job.dat) begin
            start_pos = POS_DATA_FIRST;
        end else begin
            start_pos = POS_BEL;
        end
    end

    // Skip the slots a job does not use; the end of the job is the last char.
    always_comb
    begin
        pos_next = pos_reg + 4'd1;
        cur_last = 1'b0;
        if (pos_reg == POS_HDR_LAST) begin
            if (cur_job_reg.dat) begin
                pos_next = POS_DATA_FIRST;
            end else if (cur_job_reg.bel) begin
                pos_next = POS_BEL;
            end else begin
                cur_last = 1'b1;
            end
        end else if (pos_reg == POS_DATA_LAST) begin
            if (cur_job_reg.bel) begin
                pos_next = POS_BEL;
            end else begin
                cur_last = 1'b1;
            end
        end else if (pos_reg >= POS_BEL) begin
            cur_last = 1'b1;
        end
    end

    assign slot = 2'(pos_reg - POS_DATA_FIRST);

    always_comb
    begin
        case (slot)
            2'd0:    sext = cur_job_reg.triple[23:18];
            2'd1:    sext = cur_job_reg.triple[17:12];
            2'd2:    sext = cur_job_reg.triple[11:6];
            default: sext = cur_job_reg.triple[5:0];
        endcase
    end

    always_comb
    begin
        if (pos_reg <= POS_HDR_LAST) begin
            cur_char = HDR_CHARS[pos_reg[2:0]];
        end else if (pos_reg <= POS_DATA_LAST) begin
            cur_char = ({1'b0, slot} < cur_job_reg.nsx) ? b64_char(sext) : PAD_CHAR;
        end else begin
            cur_char = BEL_CHAR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_job_reg <= q_job;
        end
        if (emit) begin
            out_char_reg <= cur_char;
            out_last_reg <= cur_last;
            out_end_reg  <= (pos_reg == POS_BEL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= POS_HDR_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= start_pos;
            end else if (emit && cur_last) begin
                cur_valid_reg <= 1'b0;
            end else if (emit) begin
                pos_reg <= pos_next;
            end
            if (out_load) begin
                out_valid_reg <= emit;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

endmodule
